[hdl/greedy_word_wrap_line_splitter_unit_assert.svh]
// Assertion macros used by the word wrap RTL.
`ifndef GREEDY_WORD_WRAP_LINE_SPLITTER_UNIT_ASSERT_SVH
`define GREEDY_WORD_WRAP_LINE_SPLITTER_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define GWW_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: label");

// A condition that implies another at the same edge.
`define GWW_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// A condition that implies another at the next edge.
`define GWW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

[hdl/gww_pkg.sv]
package gww_pkg;

   // Default text capacity in characters.
   localparam int TEXT_CAPACITY_DEFAULT = 4096;

   // Character codes with a special meaning.
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;

   // Register indexes of the configuration port.
   localparam logic [7:0] REG_LINE_COLUMNS    = 8'd0;
   localparam logic [7:0] REG_CURSOR_POSITION = 8'd1;

   // Register reset values.
   localparam logic [7:0]  LINE_COLUMNS_RESET    = 8'd80;
   localparam logic [11:0] CURSOR_POSITION_RESET = 12'd0;

   // Record kinds carried on the result channel's tuser.
   localparam logic RECORD_LINE   = 1'b0;
   localparam logic RECORD_CURSOR = 1'b1;

   // Field widths of the channels.
   localparam int CHAR_W   = 8;
   localparam int NUMBER_W = 13;
   localparam int OFFSET_W = 13;
   localparam int SIZE_W   = 8;
   localparam int COLUMN_W = 12;
   localparam int CURSOR_W = 12;
   localparam int RSP_DATA_W = 48;

   // Depth of the result queue, in items.
   localparam int QUEUE_DEPTH = 2;

   // Everything one item leaves for the result channel.
   typedef struct packed {
      logic [NUMBER_W-1:0] line_number;
      logic [OFFSET_W-1:0] line_offset;
      logic [SIZE_W-1:0]   line_size;
      logic                has_cursor;
      logic [NUMBER_W-1:0] cursor_line;
      logic [OFFSET_W-1:0] cursor_offset;
      logic [COLUMN_W-1:0] cursor_column;
   } bundle_type;

endpackage

[hdl/greedy_word_wrap_line_splitter_unit.sv]
// Greedy word wrap line splitter.
// The req channel carries one text character per transfer in req_tdata; req_tuser
// high marks the end of the text and its character is ignored. Each line that
// closes (newline, hard break of a full line without a space, or wrap after the
// last space) gives one line record on the rsp channel. The end marker gives the
// final line record and then a cursor record, the latter with rsp_tlast high.
// Characters past the text capacity are dropped silently.
// Configuration is written on the csr channel, which is always ready, while idle;
// the user must keep to that, as the block does not enforce it. The line state
// registers update at the req transfer and the records enter a two-item result
// queue in the same edge. A record appears on rsp in the cycle after its req
// transfer when the queue is empty. Characters flow at one per cycle while
// req_tready is high; the end marker gives two records on rsp, so when the next
// item also closes a line the queue fills and req_tready drops until the cursor
// record has been transferred. When the receiver stalls, the queue holds up to two
// items, after which req_tready goes low until a transfer frees a slot.
// Reset clears the line state and the queue and loads line_columns with 80 and
// cursor_position with 0.
module greedy_word_wrap_line_splitter_unit #(
   parameter int TEXT_CAPACITY = gww_pkg::TEXT_CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // Input characters.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [gww_pkg::CHAR_W-1:0]   req_tdata,  // [7:0] char_code
   input  logic                         req_tuser,  // [0] end_mark
   // Result records.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [12:0] line_number, [25:13] line_offset, [33:26] line_size,
   // [45:34] cursor_column, [47:46] zero
   output logic [gww_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                         rsp_tuser,  // [0] record_kind
   output logic                         rsp_tlast,  // final_record
   // Configuration writes.
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [7:0]                   csr_index,
   input  logic [gww_pkg::CURSOR_W-1:0] csr_data
);
   import gww_pkg::*;

`include "greedy_word_wrap_line_splitter_unit_assert.svh"

   localparam int IDX_W = $clog2(TEXT_CAPACITY + 1);
   localparam int CMP_W = (IDX_W > CURSOR_W) ? IDX_W : CURSOR_W;

   // Configuration registers.
   logic [7:0]          line_columns_ff;
   logic [CURSOR_W-1:0] cursor_position_ff;

   // Line state.
   logic [IDX_W-1:0]  char_index_ff, char_index_in;
   logic [IDX_W-1:0]  line_start_ff, line_start_in;
   logic [7:0]        col_count_ff, col_count_in;
   logic              space_seen_ff, space_seen_in;
   logic [IDX_W-1:0]  space_index_ff, space_index_in;
   logic [7:0]        space_count_ff, space_count_in;
   logic [IDX_W-1:0]  line_number_ff, line_number_in;
   logic [IDX_W-1:0]  cursor_line_ff, cursor_line_in;
   logic [IDX_W-1:0]  cursor_start_ff, cursor_start_in;

   // Result queue.
   bundle_type  queue_ff [QUEUE_DEPTH];
   logic [0:0]  wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff, count_in;
   logic        phase_ff, phase_in;

   logic        req_accept, rsp_accept, push, pop;
   bundle_type  bundle, head;

   // Per character terms.
   logic [CMP_W-1:0] cursor_clamp;
   logic [7:0]       count_next;
   logic             is_space, seen_next, line_full, hard_close, wrap_close;
   logic [IDX_W-1:0] space_index_next;
   logic [7:0]       space_count_next;
   logic [IDX_W-1:0] next_start;

   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff != 2'(QUEUE_DEPTH));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_columns_ff    <= LINE_COLUMNS_RESET;
         cursor_position_ff <= CURSOR_POSITION_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LINE_COLUMNS:    line_columns_ff    <= csr_data[7:0];
            REG_CURSOR_POSITION: cursor_position_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The cursor is clamped to the last position that the text can hold.
   always_comb begin
      if (CMP_W'(cursor_position_ff) >= CMP_W'(TEXT_CAPACITY - 1)) begin
         cursor_clamp = CMP_W'(TEXT_CAPACITY - 1);
      end else begin
         cursor_clamp = CMP_W'(cursor_position_ff);
      end
   end

   // Terms for one incoming character.
   assign count_next       = col_count_ff + 8'd1;
   assign is_space         = (req_tdata == CHAR_SPACE);
   assign seen_next        = space_seen_ff || is_space;
   assign space_index_next = is_space ? char_index_ff : space_index_ff;
   assign space_count_next = is_space ? count_next : space_count_ff;
   assign line_full        = (count_next == line_columns_ff);
   assign hard_close       = (line_full && !seen_next) || (req_tdata == CHAR_NEWLINE);
   assign wrap_close       = line_full && !hard_close;
   assign next_start       = hard_close ? (char_index_ff + IDX_W'(1))
                                        : (space_index_next + IDX_W'(1));

   // Next line state and the result bundle of the accepted item.
   always_comb begin
      char_index_in   = char_index_ff;
      line_start_in   = line_start_ff;
      col_count_in    = col_count_ff;
      space_seen_in   = space_seen_ff;
      space_index_in  = space_index_ff;
      space_count_in  = space_count_ff;
      line_number_in  = line_number_ff;
      cursor_line_in  = cursor_line_ff;
      cursor_start_in = cursor_start_ff;
      push            = 1'b0;
      bundle.line_number   = NUMBER_W'(line_number_ff);
      bundle.line_offset   = OFFSET_W'(line_start_ff);
      bundle.line_size     = col_count_ff;
      bundle.has_cursor    = 1'b0;
      bundle.cursor_line   = NUMBER_W'(cursor_line_ff);
      bundle.cursor_offset = OFFSET_W'(cursor_start_ff);
      bundle.cursor_column = '0;
      if (req_accept) begin
         if (req_tuser) begin
            // End of text: final line, cursor record, and a fresh start.
            push              = 1'b1;
            bundle.has_cursor = 1'b1;
            if (char_index_ff != '0) begin
               bundle.cursor_column = COLUMN_W'(cursor_clamp - CMP_W'(cursor_start_ff));
            end
            char_index_in   = '0;
            line_start_in   = '0;
            col_count_in    = '0;
            space_seen_in   = 1'b0;
            space_index_in  = '0;
            space_count_in  = '0;
            line_number_in  = '0;
            cursor_line_in  = '0;
            cursor_start_in = '0;
         end else if (char_index_ff < IDX_W'(TEXT_CAPACITY)) begin
            char_index_in = char_index_ff + IDX_W'(1);
            if (hard_close || wrap_close) begin
               // The line closes and the next one opens at next_start.
               push             = 1'b1;
               bundle.line_size = hard_close ? count_next : space_count_next;
               col_count_in     = hard_close ? 8'd0 : (count_next - space_count_next);
               line_number_in   = line_number_ff + IDX_W'(1);
               line_start_in    = next_start;
               space_seen_in    = 1'b0;
               space_index_in   = '0;
               space_count_in   = '0;
               if (CMP_W'(next_start) <= cursor_clamp) begin
                  cursor_line_in  = line_number_ff + IDX_W'(1);
                  cursor_start_in = next_start;
               end
            end else begin
               col_count_in   = count_next;
               space_seen_in  = seen_next;
               space_index_in = space_index_next;
               space_count_in = space_count_next;
            end
         end
      end
   end

   // Line state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         char_index_ff   <= '0;
         line_start_ff   <= '0;
         col_count_ff    <= '0;
         space_seen_ff   <= 1'b0;
         space_index_ff  <= '0;
         space_count_ff  <= '0;
         line_number_ff  <= '0;
         cursor_line_ff  <= '0;
         cursor_start_ff <= '0;
      end else begin
         char_index_ff   <= char_index_in;
         line_start_ff   <= line_start_in;
         col_count_ff    <= col_count_in;
         space_seen_ff   <= space_seen_in;
         space_index_ff  <= space_index_in;
         space_count_ff  <= space_count_in;
         line_number_ff  <= line_number_in;
         cursor_line_ff  <= cursor_line_in;
         cursor_start_ff <= cursor_start_in;
      end
   end

   // The head item leaves after its last record has been transferred.
   assign head = queue_ff[rd_ptr_ff];
   assign pop  = rsp_accept && (phase_ff || !head.has_cursor);

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
      phase_in = phase_ff;
      if (pop) begin
         phase_in = 1'b0;
      end else if (rsp_accept) begin
         phase_in = 1'b1;
      end
   end

   // Result queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

   // Result queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= bundle;
      end
   end

   // Present the line record first and the cursor record after it.
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tuser  = phase_ff ? RECORD_CURSOR : RECORD_LINE;
   assign rsp_tlast  = phase_ff;
   always_comb begin
      if (phase_ff) begin
         rsp_tdata = {2'b00, head.cursor_column, 8'd0, head.cursor_offset,
                      head.cursor_line};
      end else begin
         rsp_tdata = {2'b00, 12'd0, head.line_size, head.line_offset,
                      head.line_number};
      end
   end

   // The queue never holds more than its depth.
   `GWW_ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff <= 2'(QUEUE_DEPTH))
   // The cursor phase is only entered for an item that carries a cursor record.
   `GWW_ASSERT_IMPLIES(a_cursor_phase, clock, reset, phase_ff,
      (count_ff != 2'd0) && head.has_cursor)
   // An end marker leaves the line state back at the start of a text.
   `GWW_ASSERT_NEXT(a_end_clears, clock, reset, req_accept && req_tuser,
      (char_index_ff == '0) && (line_number_ff == '0) && (col_count_ff == 8'd0))

endmodule
